/* rtl/ccr_pkg.sv */
// constants, types and decode-table builder shared by the contrast ratio unit
package ccr_pkg;

   localparam int FracBitsDefault = 16;
   localparam int MaxLumBits      = 25;
   localparam int BigBits         = 384;
   localparam int WeightBits      = 16;

   localparam logic [WeightBits-1:0] WeightRed   = 16'd13933;
   localparam logic [WeightBits-1:0] WeightGreen = 16'd46871;
   localparam logic [WeightBits-1:0] WeightBlue  = 16'd4732;

   typedef logic [MaxLumBits-1:0] decode_table_type [256];

   // largest y with b^12 * (2y-1)^5 <= a^12 * (2^(f+1))^5
   function automatic logic [MaxLumBits-1:0] curve_entry(int frac_bits, int v);
      logic [BigBits-1:0] rhs;
      logic [BigBits-1:0] bpow;
      logic [BigBits-1:0] lhs;
      logic [31:0]        a;
      logic [31:0]        lo;
      logic [31:0]        hi;
      logic [31:0]        mid;
      a    = 32'(1000 * v + 14025);
      rhs  = BigBits'(1);
      bpow = BigBits'(1);
      lo   = 32'd1;
      hi   = 32'd1 << frac_bits;
      for (int i = 0; i < 12; i++) begin
         rhs  = rhs * BigBits'(a);
         bpow = bpow * BigBits'(269025);
      end
      for (int i = 0; i < 5; i++) begin
         rhs = rhs << (frac_bits + 1);
      end
      for (int s = 0; s < 32; s++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 32'd1) >> 1);
            lhs = bpow;
            for (int i = 0; i < 5; i++) begin
               lhs = lhs * BigBits'(2 * mid - 32'd1);
            end
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 32'd1;
            end
         end
      end
      return lo[MaxLumBits-1:0];
   endfunction

   function automatic decode_table_type build_decode_table(int frac_bits);
      decode_table_type   t;
      longint unsigned    num;
      for (int v = 0; v < 256; v++) begin
         if (v <= 10) begin
            num  = longint'(v) * (longint'(100) << frac_bits) + 64'd164730;
            t[v] = MaxLumBits'(num / 64'd329460);
         end else begin
            t[v] = curve_entry(frac_bits, v);
         end
      end
      return t;
   endfunction

endpackage

/* rtl/color_contrast_ratio_unit.sv */
// color contrast ratio unit: sRGB decode, luminance, ordering and pipelined divide
//
// A request carries two 8-bit RGB colors and is taken at a rising edge with start
// high and busy low. busy is always low: the pipeline takes one request every
// cycle. Each request gives one result, shown for exactly one cycle with rsp_valid
// high: the contrast ratio (L1+0.05)/(L2+0.05) in unsigned Q5.FRAC_BITS and the
// lighter and darker luminance in Q1.FRAC_BITS.
// Each request passes through table lookup, weight multiply, luminance sum,
// ordering, then FRAC_BITS+5 restoring divider stages, one quotient bit each.
// Results leave in request order. Throughput is one result per cycle.
// Reset clears every stage valid bit; requests in flight are dropped.
// The receiver cannot stall, so results are never held.
module color_contrast_ratio_unit
   import ccr_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [7:0]           req_first_red,
   input  logic [7:0]           req_first_green,
   input  logic [7:0]           req_first_blue,
   input  logic [7:0]           req_second_red,
   input  logic [7:0]           req_second_green,
   input  logic [7:0]           req_second_blue,
   output logic                 rsp_valid,
   output logic [FRAC_BITS+4:0] rsp_contrast_ratio,
   output logic [FRAC_BITS:0]   rsp_lighter_luminance,
   output logic [FRAC_BITS:0]   rsp_darker_luminance
);

   localparam int LW = FRAC_BITS + 1;
   localparam int PW = LW + WeightBits;
   localparam int SW = PW + 2;
   localparam int DW = FRAC_BITS + 2;
   localparam int QW = FRAC_BITS + 5;
   localparam int RW = 2 * FRAC_BITS + 2;
   localparam int CW = 2 * FRAC_BITS + 6;
   localparam logic [LW-1:0] OffsetK = LW'(((1 << FRAC_BITS) + 10) / 20);
   localparam decode_table_type DecodeTable = build_decode_table(FRAC_BITS);

   logic              accept;
   logic              s1_valid_ff;
   logic [LW-1:0]     lin_ff [6];
   logic              s2_valid_ff;
   logic [PW-1:0]     prod_ff [6];
   logic              s3_valid_ff;
   logic [LW-1:0]     lum_a_ff;
   logic [LW-1:0]     lum_b_ff;
   logic [SW-1:0]     sum_a_in;
   logic [SW-1:0]     sum_b_in;
   logic              a_larger;
   logic [LW-1:0]     l1_in;
   logic [LW-1:0]     l2_in;

   logic              div_valid_ff [QW+1];
   logic [RW-1:0]     div_rem_ff   [QW+1];
   logic [DW-1:0]     div_den_ff   [QW+1];
   logic [LW-1:0]     div_l1_ff    [QW+1];
   logic [LW-1:0]     div_l2_ff    [QW+1];
   logic [QW-1:0]     div_quo_ff   [QW+1];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // stage 1: gamma decode
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff[0] <= DecodeTable[req_first_red][LW-1:0];
      lin_ff[1] <= DecodeTable[req_first_green][LW-1:0];
      lin_ff[2] <= DecodeTable[req_first_blue][LW-1:0];
      lin_ff[3] <= DecodeTable[req_second_red][LW-1:0];
      lin_ff[4] <= DecodeTable[req_second_green][LW-1:0];
      lin_ff[5] <= DecodeTable[req_second_blue][LW-1:0];
   end

   // stage 2: channel weights
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff[0] <= PW'(lin_ff[0]) * PW'(WeightRed);
      prod_ff[1] <= PW'(lin_ff[1]) * PW'(WeightGreen);
      prod_ff[2] <= PW'(lin_ff[2]) * PW'(WeightBlue);
      prod_ff[3] <= PW'(lin_ff[3]) * PW'(WeightRed);
      prod_ff[4] <= PW'(lin_ff[4]) * PW'(WeightGreen);
      prod_ff[5] <= PW'(lin_ff[5]) * PW'(WeightBlue);
   end

   // stage 3: luminance sums
   always_comb begin
      sum_a_in = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);
      sum_b_in = SW'(prod_ff[3]) + SW'(prod_ff[4]) + SW'(prod_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lum_a_ff <= sum_a_in[WeightBits +: LW];
      lum_b_ff <= sum_b_in[WeightBits +: LW];
   end

   // stage 4: ordering and divider operands
   always_comb begin
      a_larger = lum_a_ff > lum_b_ff;
      l1_in    = a_larger ? lum_a_ff : lum_b_ff;
      l2_in    = a_larger ? lum_b_ff : lum_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      div_l1_ff[0]  <= l1_in;
      div_l2_ff[0]  <= l2_in;
      div_rem_ff[0] <= RW'({1'b0, l1_in} + {1'b0, OffsetK}) << FRAC_BITS;
      div_den_ff[0] <= DW'({1'b0, l2_in} + {1'b0, OffsetK});
      div_quo_ff[0] <= '0;
   end

   // restoring divider, one quotient bit per stage, msb first
   for (genvar j = 1; j <= QW; j++) begin : g_div
      localparam int Bit = QW - j;
      logic [CW-1:0] shifted;
      logic [CW:0]   trial;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      always_comb begin
         shifted = CW'(div_den_ff[j-1]) << Bit;
         trial   = {1'b0, CW'(div_rem_ff[j-1])} - {1'b0, shifted};
         take    = ~trial[CW];
         rem_in  = take ? RW'(trial) : div_rem_ff[j-1];
         quo_in  = div_quo_ff[j-1] | (QW'(take) << Bit);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j] <= 1'b0;
         end else begin
            div_valid_ff[j] <= div_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         div_rem_ff[j] <= rem_in;
         div_den_ff[j] <= div_den_ff[j-1];
         div_quo_ff[j] <= quo_in;
         div_l1_ff[j]  <= div_l1_ff[j-1];
         div_l2_ff[j]  <= div_l2_ff[j-1];
      end
   end

   assign rsp_valid             = div_valid_ff[QW];
   assign rsp_contrast_ratio    = div_quo_ff[QW];
   assign rsp_lighter_luminance = div_l1_ff[QW];
   assign rsp_darker_luminance  = div_l2_ff[QW];

endmodule
